// ===== design/tsma_pkg.sv =====
// ---------------------------------------------------------------------------
// Temperature sensor moving average package
// Shared widths, conversion constants, controller states and the command and
// status groups that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tsma_pkg;

   localparam int CODE_W        = 12;
   localparam int TEMP_W        = 19;
   localparam int DEPTH_DEFAULT = 30;

   // code * 307200 / 4095 = 75 * code + (75 * code) / 4095
   localparam int CONV_MUL    = 75;
   localparam int CONV_DEN    = 4095;
   localparam int DEN_SHIFT   = 12;
   localparam int CONV_OFFSET = 71424;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_DELIVER
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic convert;
      logic accumulate;
      logic div_load;
      logic div_step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

endpackage : tsma_pkg

`default_nettype wire

// ===== design/tsma_channels.sv =====
// ---------------------------------------------------------------------------
// Temperature sensor moving average channels
// Valid/ready interfaces for the ADC code input and the averaged result.
// ---------------------------------------------------------------------------
`default_nettype none

interface tsma_req_if;
   import tsma_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface : tsma_req_if

interface tsma_rsp_if;
   import tsma_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] avg_temp;
   logic signed [TEMP_W-1:0] sample_temp;

   modport source (output valid, output avg_temp, output sample_temp, input ready);
   modport sink   (input valid, input avg_temp, input sample_temp, output ready);
endinterface : tsma_rsp_if

`default_nettype wire

// ===== design/tsma_ctrl.sv =====
// ---------------------------------------------------------------------------
// Temperature sensor moving average controller
// Sequences one sample through conversion, window update, division and
// delivery, and owns the handshake flags of both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module tsma_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output tsma_pkg::dp_cmd_type         cmd,
   input  wire tsma_pkg::dp_status_type status
);
   import tsma_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   logic           req_fire;
   logic           out_free;

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in       = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            // The result waits here until the output register is free.
            if (out_free) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_CONVERT)
      else $error("accepted sample did not start conversion");

   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && status.div_last) |=> state_ff == ST_DELIVER)
      else $error("division did not hand over to delivery");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_ready))
      else $error("output register loaded over a pending result");

endmodule : tsma_ctrl

`default_nettype wire

// ===== design/tsma_dp.sv =====
// ---------------------------------------------------------------------------
// Temperature sensor moving average datapath
// ADC code to Q.8 conversion, sample window memory, running sum, serial
// divider for the mean and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tsma_dp #(
   parameter int DEPTH = tsma_pkg::DEPTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire tsma_pkg::dp_cmd_type           cmd,
   output tsma_pkg::dp_status_type             status,
   input  wire  [tsma_pkg::CODE_W-1:0]         adc_code,
   output logic signed [tsma_pkg::TEMP_W-1:0]  avg_temp,
   output logic signed [tsma_pkg::TEMP_W-1:0]  sample_temp
);
   import tsma_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W  = TEMP_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int QEST_W = TEMP_W - DEN_SHIFT;
   localparam int REM_W  = DEN_SHIFT + 1;

   // Window memory, no reset: slots not yet written are masked by the fill count.
   logic signed [TEMP_W-1:0] sample_ring_ff [DEPTH];

   logic [CODE_W-1:0]        code_ff, code_in;
   logic signed [TEMP_W-1:0] old_raw_ff;
   logic                     old_used_ff, old_used_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]         quot_ff, quot_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]         divisor_ff, divisor_in;
   logic                     neg_ff, neg_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [TEMP_W-1:0] avg_ff, avg_in;
   logic signed [TEMP_W-1:0] sample_ff, sample_in;

   logic [TEMP_W-1:0]        times_mul;
   logic [QEST_W-1:0]        quot_est;
   logic [REM_W-1:0]         rem_est;
   logic                     rem_carry;
   logic [TEMP_W-1:0]        scaled;
   logic signed [TEMP_W-1:0] old_val;
   logic [SUM_W-1:0]         sum_mag;
   logic [CNT_W:0]           trial;
   logic                     fits;
   logic [TEMP_W-1:0]        mag_low;

   // Division by 4095 = 4096 - 1: the shifted estimate is short by at most one.
   always_comb begin
      times_mul = TEMP_W'(code_ff) * TEMP_W'(CONV_MUL);
      quot_est  = times_mul[TEMP_W-1:DEN_SHIFT];
      rem_est   = {1'b0, times_mul[DEN_SHIFT-1:0]} + REM_W'(quot_est);
      rem_carry = rem_est >= REM_W'(CONV_DEN);
      scaled    = times_mul + TEMP_W'(quot_est) + TEMP_W'(rem_carry);
   end

   always_comb begin
      old_val = old_used_ff ? old_raw_ff : '0;
      sum_mag = sum_ff[SUM_W-1] ? unsigned'(-sum_ff) : unsigned'(sum_ff);
      trial   = {rem_ff, quot_ff[SUM_W-1]};
      fits    = trial >= {1'b0, divisor_ff};
      mag_low = quot_ff[TEMP_W-1:0];
      status.div_last = step_ff == STEP_W'(SUM_W - 1);
   end

   always_comb begin
      code_in     = code_ff;
      old_used_in = old_used_ff;
      temp_in     = temp_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      neg_in      = neg_ff;
      step_in     = step_ff;
      avg_in      = avg_ff;
      sample_in   = sample_ff;

      if (cmd.capture) begin
         code_in     = adc_code;
         old_used_in = count_ff == CNT_W'(DEPTH);
      end
      if (cmd.convert) begin
         temp_in = signed'(scaled - TEMP_W'(CONV_OFFSET));
      end
      if (cmd.accumulate) begin
         sum_in   = sum_ff - SUM_W'(old_val) + SUM_W'(temp_ff);
         slot_in  = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         count_in = (count_ff == CNT_W'(DEPTH)) ? count_ff : count_ff + 1'b1;
      end
      if (cmd.div_load) begin
         quot_in    = sum_mag;
         rem_in     = '0;
         divisor_in = count_ff;
         neg_in     = sum_ff[SUM_W-1];
         step_in    = '0;
      end
      if (cmd.div_step) begin
         rem_in  = fits ? CNT_W'(trial - {1'b0, divisor_ff}) : trial[CNT_W-1:0];
         quot_in = {quot_ff[SUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
      end
      if (cmd.out_load) begin
         avg_in    = neg_ff ? -signed'(mag_low) : signed'(mag_low);
         sample_in = temp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accumulate) begin
         sample_ring_ff[slot_ff] <= temp_ff;
      end
      if (cmd.capture) begin
         old_raw_ff <= sample_ring_ff[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         step_ff  <= '0;
      end else begin
         slot_ff  <= slot_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      old_used_ff <= old_used_in;
      temp_ff     <= temp_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
      avg_ff      <= avg_in;
      sample_ff   <= sample_in;
   end

   assign avg_temp    = avg_ff;
   assign sample_temp = sample_ff;

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.accumulate |=> count_ff != '0)
      else $error("sample count is zero after a window update");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("sample count above window depth");

endmodule : tsma_dp

`default_nettype wire

// ===== design/temp_sensor_moving_average.sv =====
// A result passes through the convert, accumulate, divide-load, divide and
// deliver states after its sample transfer; the one-bit-per-cycle divider
// forms the mean of the SUM_W = 19 + clog2(DEPTH + 1) bit running sum, and
// deliver waits for a free output register. No new sample is taken while one
// is in flight; a pending result does not block the next sample transfer.
// Synchronous reset clears window, sum and counters; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Temperature sensor moving average
// Converts raw ADC codes to Q.8 degrees Celsius and reports the boxcar mean
// over the last DEPTH samples together with the converted sample.
// ---------------------------------------------------------------------------
`default_nettype none

module temp_sensor_moving_average #(
   parameter int DEPTH = tsma_pkg::DEPTH_DEFAULT
) (
   input wire          clock,
   input wire          reset,
   tsma_req_if.sink    req_channel,
   tsma_rsp_if.source  rsp_channel
);
   import tsma_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tsma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tsma_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .adc_code    (req_channel.adc_code),
      .avg_temp    (rsp_channel.avg_temp),
      .sample_temp (rsp_channel.sample_temp)
   );

endmodule : temp_sensor_moving_average

`default_nettype wire
